// ----- rtl/core/usm_pkg.sv -----
`timescale 1ns / 1ps
package usm_pkg;

  // Grid and coordinate format
  localparam int MAX_GRID        = 256;
  localparam int COORD_FRAC_BITS = 15;
  localparam int CFG_W           = 9;
  localparam int IDX_W           = 17;
  localparam int COORD_W         = 16;

  // Register indexes
  localparam logic REG_RING   = 1'b0;
  localparam logic REG_SECTOR = 1'b1;

  // Long divider: floor(n * 2^33 / d), one quotient bit per step
  localparam int DIV_STEPS  = 34;
  localparam int DIV_PER    = 4;
  localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
  localparam int DIV_Q_W    = DIV_STEPS;
  localparam int DIV_R_W    = CFG_W + 1;
  localparam int TEX_SH     = DIV_STEPS - 1 - (COORD_FRAC_BITS + 1);

  // Sine evaluation, Q2.30
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int          HORNER_N    = 5;
  localparam logic [6:0]  HORNER_DIV   [HORNER_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  // floor(2^32 / divisor): estimate is exact or one low
  localparam logic [29:0] HORNER_RECIP [HORNER_N] = '{30'd39045157, 30'd59652323,
                                                      30'd102261126, 30'd214748364,
                                                      30'd715827882};
  localparam int SIN_STAGES = 3 + 3 * HORNER_N + 1;

  // Side pipeline: input stage, divider, sine, product stage
  localparam int PIPE_DEPTH = 1 + DIV_STAGES + SIN_STAGES + 1;
  localparam int TEX_STAGE  = DIV_STAGES + 1;

  localparam int ROUND_SH  = 30 - COORD_FRAC_BITS;
  localparam int COORD_MAX = (1 << COORD_FRAC_BITS) - 1;

  typedef struct packed {
    logic             mode;
    logic [CFG_W-1:0] ring_index;
    logic [CFG_W-1:0] sector_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [COORD_W-1:0]        tex_u;
    logic [COORD_W-1:0]        tex_v;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic [IDX_W-1:0]          index_c;
    logic                      last;
    logic                      bad_request;
  } out_item_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } sin_res_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] t;
    logic [31:0] t2;
  } sin_ctx_t;

  typedef struct packed {
    logic               mode;
    logic               bad;
    logic [IDX_W-1:0]   cur;
    logic [IDX_W-1:0]   nxt;
    logic [COORD_W-1:0] tex_u;
    logic [COORD_W-1:0] tex_v;
  } side_t;

endpackage

// ----- rtl/core/usm_div.sv -----
`timescale 1ns / 1ps
module usm_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [usm_pkg::CFG_W-1:0]    num,
  input  logic [usm_pkg::CFG_W-1:0]    den,
  output logic [usm_pkg::DIV_Q_W-1:0]  quo
);
  import usm_pkg::*;

  logic [DIV_R_W-1:0] rem_q [DIV_STAGES-1];
  logic [DIV_Q_W-1:0] quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_R_W-1:0] r_in;
    logic [DIV_R_W-1:0] r_c;
    logic [DIV_Q_W-1:0] q_in;
    logic [DIV_Q_W-1:0] q_c;

    if (s == 0) begin : g_first
      assign r_in = {1'b0, num};
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign q_in = quo_q[s-1];
    end

    // shift, compare, subtract: one quotient bit per step
    always_comb begin
      r_c = r_in;
      q_c = q_in;
      for (int j = 0; j < DIV_PER; j++) begin
        if (s * DIV_PER + j < DIV_STEPS) begin
          if (s * DIV_PER + j != 0) r_c = {r_c[DIV_R_W-2:0], 1'b0};
          if (r_c >= {1'b0, den}) begin
            r_c = r_c - {1'b0, den};
            q_c = {q_c[DIV_Q_W-2:0], 1'b1};
          end else begin
            q_c = {q_c[DIV_Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) quo_q[s] <= q_c;
    end

    if (s < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) rem_q[s] <= r_c;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

// ----- rtl/core/usm_sin.sv -----
`timescale 1ns / 1ps
module usm_sin (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       angle,
  input  logic              cos_sel,
  output usm_pkg::sin_res_t res
);
  import usm_pkg::*;

  logic [1:0]  quad;
  logic        neg_a;
  logic [30:0] f_a;
  logic        neg_b;
  logic [30:0] t_b;
  logic [61:0] t_prod;
  logic [61:0] t2_prod;
  sin_ctx_t    ctx_c;
  sin_ctx_t    ctx_r [3*HORNER_N];
  logic [31:0] x_m [HORNER_N];
  logic [31:0] x_r [HORNER_N];
  logic [29:0] q_r [HORNER_N];
  logic [30:0] r_c [HORNER_N];
  logic [61:0] f_prod;

  // quadrant reduction; cosine is the next quadrant
  assign quad   = angle[31:30] + {1'b0, cos_sel};
  assign t_prod = 62'(f_a) * 62'(HALF_PI_Q30);
  assign t2_prod = 62'(t_b) * 62'(t_b);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= quad[1];
      f_a   <= quad[0] ? (Q30_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
      neg_b <= neg_a;
      t_b   <= t_prod[60:30];
      ctx_c <= '{neg: neg_b, t: t_b, t2: t2_prod[61:30]};
    end
  end

  // Horner rounds: multiply, reciprocal estimate, correct and subtract from one
  for (genvar k = 0; k < HORNER_N; k++) begin : g_round
    logic [62:0] xp;
    logic [61:0] rp;
    logic [36:0] qc;
    logic        fix;

    if (k == 0) begin : g_first
      assign xp = '0;
      always_ff @(posedge clk) begin
        if (en) begin
          ctx_r[0] <= ctx_c;
          x_m[0]   <= ctx_c.t2;
        end
      end
    end else begin : g_next
      assign xp = 63'(ctx_r[3*k-1].t2) * 63'(r_c[k-1]);
      always_ff @(posedge clk) begin
        if (en) begin
          ctx_r[3*k] <= ctx_r[3*k-1];
          x_m[k]     <= xp[61:30];
        end
      end
    end

    assign rp  = 62'(x_m[k]) * 62'(HORNER_RECIP[k]);
    assign qc  = 37'(q_r[k]) * 37'(HORNER_DIV[k]);
    assign fix = (x_r[k] - qc[31:0]) >= 32'(HORNER_DIV[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[3*k+1] <= ctx_r[3*k];
        x_r[k]       <= x_m[k];
        q_r[k]       <= rp[61:32];
        ctx_r[3*k+2] <= ctx_r[3*k+1];
        r_c[k]       <= Q30_ONE - (31'(q_r[k]) + 31'(fix));
      end
    end
  end

  assign f_prod = 62'(ctx_r[3*HORNER_N-1].t) * 62'(r_c[HORNER_N-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      res.neg <= ctx_r[3*HORNER_N-1].neg;
      res.mag <= f_prod[61:30];
    end
  end

endmodule

// ----- rtl/core/uv_sphere_mesh_generator.sv -----
`timescale 1ns / 1ps
// UV sphere tessellation pipeline.
// Input channel (in_valid/in_ready/in_data) takes one grid request per item:
// mode 0 asks for the vertex at (ring_index, sector_index), mode 1 for the two
// triangles of the quad at that corner. Output channel (out_valid/out_ready/
// out_data) returns one item per vertex or refused request and two items per
// quad, the second flagged with last.
// Configuration: cfg_wen writes cfg_wdata into ring_count (cfg_addr 0) or
// sector_count (cfg_addr 1); write only while no item is in flight.
// Path to out_valid: the accepting edge loads the input stage, then the
// 9-stage angle divider, the 19-stage sine evaluator, the product stage and
// the output register follow.
// Throughput: one item per cycle for vertices while the receiver takes every
// item; a quad holds the input while its second triangle is shown.
// The whole pipeline advances on one enable: when the output register holds
// an item that is not taken, every stage holds, so a stalled receiver loses
// and repeats nothing. Reset clears all valid bits and loads ring_count 16
// and sector_count 32.
module uv_sphere_mesh_generator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  usm_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output usm_pkg::out_item_t        out_data,
  input  logic                      cfg_wen,
  input  logic                      cfg_addr,
  input  logic [usm_pkg::CFG_W-1:0] cfg_wdata
);
  import usm_pkg::*;

  logic [CFG_W-1:0] ring_count;
  logic [CFG_W-1:0] sector_count;

  logic             adv;
  logic             vld [PIPE_DEPTH];
  side_t            side [PIPE_DEPTH];
  side_t            s0;
  side_t            tex_side;
  logic [CFG_W-1:0] ring0;
  logic [CFG_W-1:0] sec0;

  logic             cnt_ok;
  logic             grid_ok;
  logic [CFG_W:0]   sc_p1;
  logic [19:0]      row_base;
  logic [IDX_W-1:0] cur_c;

  logic [DIV_Q_W-1:0] quo_r;
  logic [DIV_Q_W-1:0] quo_s;
  logic [DIV_Q_W:0]   theta_sum;
  logic [DIV_Q_W-1:0] phi_sum;
  logic [31:0]        phi;
  logic [31:0]        theta;
  logic [17:0]        texu_sum;
  logic [17:0]        texv_sum;

  sin_res_t sp;
  sin_res_t cp;
  sin_res_t st;
  sin_res_t ct;

  logic        px_neg;
  logic [31:0] px_mag;
  logic        pz_neg;
  logic [31:0] pz_mag;
  sin_res_t    py;
  logic [63:0] px_prod;
  logic [63:0] pz_prod;

  logic      pv;
  out_item_t pend;
  out_item_t first_c;
  out_item_t second_c;
  side_t     sl;
  logic      vertex;
  logic      tri_item;

  // Q2.30 magnitude and sign to Q1.15: round half up, saturate, restore sign
  function automatic logic [COORD_W-1:0] to_coord(input logic neg, input logic [31:0] m);
    logic [32:0]          s;
    logic [32:0]          mr;
    logic [COORD_W-1:0]   sat;
    s   = 33'(m) + (33'(1) << (ROUND_SH - 1));
    mr  = s >> ROUND_SH;
    sat = (mr > 33'(COORD_MAX)) ? COORD_W'(COORD_MAX) : mr[COORD_W-1:0];
    return neg ? (~sat + 1'b1) : sat;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count   <= CFG_W'(16);
      sector_count <= CFG_W'(32);
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_RING:   ring_count   <= cfg_wdata;
        REG_SECTOR: sector_count <= cfg_wdata;
      endcase
    end
  end

  // advance everything when the output register can take a new item
  assign adv      = !out_valid || (out_ready && !pv);
  assign in_ready = adv;

  // input stage: range checks and quad corner indices
  assign cnt_ok = (ring_count != '0) && (sector_count != '0) &&
                  (ring_count <= CFG_W'(MAX_GRID)) && (sector_count <= CFG_W'(MAX_GRID));
  assign grid_ok = in_data.mode ?
                   (in_data.ring_index < ring_count && in_data.sector_index < sector_count) :
                   (in_data.ring_index <= ring_count && in_data.sector_index <= sector_count);
  assign sc_p1    = {1'b0, sector_count} + 1'b1;
  assign row_base = 20'(in_data.ring_index) * 20'(sc_p1);
  assign cur_c    = IDX_W'(row_base) + IDX_W'(in_data.sector_index);

  always_comb begin
    s0       = '0;
    s0.mode  = in_data.mode;
    s0.bad   = !(cnt_ok && grid_ok);
    s0.cur   = cur_c;
    s0.nxt   = cur_c + IDX_W'(sc_p1);
  end

  // angles as turn fractions: phi = ring / (2 rc), theta = sec / sc
  usm_div u_div_ring (
    .clk (clk),
    .en  (adv),
    .num (ring0),
    .den (ring_count),
    .quo (quo_r)
  );

  usm_div u_div_sec (
    .clk (clk),
    .en  (adv),
    .num (sec0),
    .den (sector_count),
    .quo (quo_s)
  );

  // round half up: floor((q + 1) / 2)
  assign theta_sum = {1'b0, quo_s} + 1'b1;
  assign theta     = theta_sum[32:1];
  assign phi_sum   = {1'b0, quo_r[DIV_Q_W-1:1]} + 1'b1;
  assign phi       = phi_sum[32:1];
  assign texu_sum  = 18'(quo_s >> TEX_SH) + 1'b1;
  assign texv_sum  = 18'(quo_r >> TEX_SH) + 1'b1;

  usm_sin u_sin_phi (.clk(clk), .en(adv), .angle(phi),   .cos_sel(1'b0), .res(sp));
  usm_sin u_cos_phi (.clk(clk), .en(adv), .angle(phi),   .cos_sel(1'b1), .res(cp));
  usm_sin u_sin_th  (.clk(clk), .en(adv), .angle(theta), .cos_sel(1'b0), .res(st));
  usm_sin u_cos_th  (.clk(clk), .en(adv), .angle(theta), .cos_sel(1'b1), .res(ct));

  // product stage
  assign px_prod = 64'(sp.mag) * 64'(ct.mag);
  assign pz_prod = 64'(sp.mag) * 64'(st.mag);

  always_ff @(posedge clk) begin
    if (adv) begin
      ring0  <= in_data.ring_index;
      sec0   <= in_data.sector_index;
      px_neg <= sp.neg ^ ct.neg;
      px_mag <= px_prod[61:30];
      pz_neg <= sp.neg ^ st.neg;
      pz_mag <= pz_prod[61:30];
      py     <= cp;
    end
  end

  // side pipeline: valid bits and request info ride alongside the math
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < PIPE_DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  // merge the texture coordinates once the quotients are out of the divider
  always_comb begin
    tex_side       = side[TEX_STAGE-1];
    tex_side.tex_u = texu_sum[COORD_W:1];
    tex_side.tex_v = texv_sum[COORD_W:1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= s0;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (i == TEX_STAGE) side[i] <= tex_side;
        else side[i] <= side[i-1];
      end
    end
  end

  // result assembly
  assign sl       = side[PIPE_DEPTH-1];
  assign vertex   = !sl.mode && !sl.bad;
  assign tri_item = sl.mode && !sl.bad;

  always_comb begin
    first_c             = '0;
    first_c.bad_request = sl.bad;
    first_c.last        = !tri_item;
    if (vertex) begin
      first_c.pos_x = to_coord(px_neg, px_mag);
      first_c.pos_y = to_coord(py.neg, py.mag);
      first_c.pos_z = to_coord(pz_neg, pz_mag);
      first_c.tex_u = sl.tex_u;
      first_c.tex_v = sl.tex_v;
    end
    if (tri_item) begin
      first_c.index_a = sl.cur;
      first_c.index_b = sl.nxt;
      first_c.index_c = sl.cur + 1'b1;
    end
    second_c         = '0;
    second_c.index_a = sl.cur + 1'b1;
    second_c.index_b = sl.nxt;
    second_c.index_c = sl.nxt + 1'b1;
    second_c.last    = 1'b1;
  end

  // output register plus a hold slot for a quad's second triangle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[PIPE_DEPTH-1];
      pv        <= vld[PIPE_DEPTH-1] && tri_item;
    end else if (out_valid && out_ready && pv) begin
      pv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= first_c;
      pend     <= second_c;
    end else if (out_valid && out_ready && pv) begin
      out_data <= pend;
    end
  end

  // a pending second triangle always sits behind a shown first one
  a_pend_valid: assert property (@(posedge clk) disable iff (rst) pv |-> out_valid)
    else $error("second triangle pending without a shown item");

  a_pend_first: assert property (@(posedge clk) disable iff (rst) pv |-> !out_data.last)
    else $error("item ahead of a pending triangle marked last");

  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_request) |-> out_data.last)
    else $error("refused request not marked last");

  a_no_accept: assert property (@(posedge clk) disable iff (rst) pv |-> !in_ready)
    else $error("item accepted while second triangle pending");

endmodule
